[hw/rtl/assert_macros.svh]
// Assertion macros for RTL files that check their own behavior.
// Each macro expects signals named clk and rst in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

[hw/rtl/arc_pkg.sv]
// Shared types and constants for the ARC replacement tracker.
// No dependencies; used by arc_replacement_tracker.
`timescale 1ns / 1ps
package arc_pkg;
  localparam int KEY_W   = 12;
  localparam int FIELD_W = 13;
  localparam int TOTAL_W = 32;
  localparam logic [FIELD_W-1:0] CAP_RESET = 13'd1024;

  typedef enum logic [1:0] {
    OP_GET = 2'd0,
    OP_SET = 2'd1,
    OP_DEL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    L_T1 = 2'd0,
    L_B1 = 2'd1,
    L_T2 = 2'd2,
    L_B2 = 2'd3
  } list_t;

  localparam logic REG_CAPACITY    = 1'b0;
  localparam logic REG_SET_ON_MISS = 1'b1;

  typedef struct packed {
    logic [1:0]       operation;
    logic [KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] resident_count;
    logic [FIELD_W-1:0] target_recent;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
  } result_t;
endpackage

[hw/rtl/arc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module arc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/arc_div.sv]
// Restoring divider, one quotient bit per cycle, for the ghost-list ratio.
// No package dependencies.
`timescale 1ns / 1ps
module arc_div #(
  parameter int W = 13
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [W-1:0] quo,
  output logic         done
);
  localparam int SW = $clog2(W + 1);

  logic [W:0]    rem;
  logic [W:0]    rem_sh;
  logic [W-1:0]  d;
  logic [SW-1:0] steps;
  logic          run;

  assign rem_sh = {rem[W-1:0], quo[W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= '0;
        quo   <= num;
        d     <= den;
        steps <= SW'(W);
        run   <= 1'b1;
      end else if (run) begin
        if (rem_sh >= {1'b0, d}) begin
          rem <= rem_sh - {1'b0, d};
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[W-2:0], 1'b0};
        end
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[hw/rtl/arc_replacement_tracker.sv]
// Top level of the ARC replacement tracker: sequencer, list heads and counts.
// Depends on arc_pkg, arc_ram, arc_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  channel   direction  handshake                         payload
//  --------  ---------  --------------------------------  ------------------
//  request   in         start & !busy                     arc_pkg::request_t
//  result    out        done (one cycle, no back-pressure) arc_pkg::result_t
//  config    in         psel & penable & pwrite & pready  pwdata, paddr
//
//  The time from the accepting edge to the result depends on the list changes
//  made; a ghost hit whose ratio is not one also waits for the divider. Each
//  move of an LRU entry into a ghost list and each trim lengthen the walk, all
//  set by the single node RAM port. After rst the node RAM is swept clean with
//  busy high; results cannot be stalled, done pulses once per request.
//
module arc_replacement_tracker #(
  parameter int NUM_KEYS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  arc_pkg::request_t   request,
  output logic                done,
  output arc_pkg::result_t    result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int FW  = arc_pkg::FIELD_W;
  localparam int AW  = $clog2(NUM_KEYS);
  localparam int PW  = $clog2(NUM_KEYS + 1);
  localparam int CW  = PW;
  localparam int XW  = ((CW > FW) ? CW : FW) + 2;
  localparam int NW  = 3 + 2 * PW;
  localparam logic [PW-1:0] NULLP = PW'(NUM_KEYS);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DEC, S_DIVW, S_ADAPT,
    S_RM_P_RD, S_RM_P_WR, S_RM_N_RD, S_RM_N_WR, S_RM_K_WR,
    S_IN_K_WR, S_IN_H_RD, S_IN_H_WR,
    S_REP1, S_REP2, S_TRIM1, S_TRIM2, S_LRU, S_FIN
  } state_t;

  state_t state;
  state_t ret;

  // Configuration.
  logic [FW-1:0] capacity;
  logic          set_on_miss;
  logic          cfg_wr;

  // List bookkeeping: heads are MRU, tails are LRU.
  logic [PW-1:0] head [4];
  logic [PW-1:0] tail [4];
  logic [CW-1:0] cnt  [4];
  logic [FW-1:0] target;
  logic [31:0]   hit_cnt;
  logic [31:0]   miss_cnt;

  // Working registers of the current walk.
  logic [1:0]     op_q;
  logic           in_range_q;
  logic           hit_q;
  logic           new_key;
  logic           ins_en;
  logic           ratio_one_q;
  arc_pkg::list_t cur_list;
  arc_pkg::list_t dst;
  logic [PW-1:0]  cur;
  logic [PW-1:0]  cur_prev;
  logic [PW-1:0]  cur_next;
  logic [AW-1:0]  clr_addr;

  // Node RAM.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [NW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [NW-1:0] ram_rdata;

  logic           rd_vld;
  arc_pkg::list_t rd_lst;
  logic [PW-1:0]  rd_prev;
  logic [PW-1:0]  rd_next;

  // Decode of the accessed key.
  logic          in_range;
  logic          rd_hit;
  logic          do_acc;
  logic          do_del;
  logic [CW-1:0] mine;
  logic [CW-1:0] other;
  logic          ratio_one;
  logic          div_start;
  logic [CW-1:0] div_quo;
  logic          div_done;

  // Replacement and trim decisions.
  arc_pkg::list_t drop_src;
  logic           drop_cond;
  logic [XW-1:0]  res_x;
  logic [XW-1:0]  cap_x;
  logic [XW-1:0]  tgt_x;
  logic [XW-1:0]  all_x;
  logic [CW-1:0]  rr;
  logic [XW-1:0]  np_x;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign busy   = (state != S_IDLE);
  assign prdata = (paddr[2] == arc_pkg::REG_SET_ON_MISS) ? {31'd0, set_on_miss}
                                                         : {19'd0, capacity};

  assign rd_vld  = ram_rdata[NW-1];
  assign rd_lst  = arc_pkg::list_t'(ram_rdata[NW-2 -: 2]);
  assign rd_prev = ram_rdata[2*PW-1 -: PW];
  assign rd_next = ram_rdata[PW-1:0];

  assign in_range = ({20'd0, request.key} < 32'(NUM_KEYS));
  assign rd_hit   = rd_vld && (rd_lst == arc_pkg::L_T1 || rd_lst == arc_pkg::L_T2);

  assign do_acc = in_range_q && ((op_q == arc_pkg::OP_SET) ||
                  ((op_q == arc_pkg::OP_GET) && (rd_hit || set_on_miss)));
  assign do_del = in_range_q && (op_q == arc_pkg::OP_DEL) && rd_hit;

  assign mine      = (rd_lst == arc_pkg::L_B1) ? cnt[arc_pkg::L_B1] : cnt[arc_pkg::L_B2];
  assign other     = (rd_lst == arc_pkg::L_B1) ? cnt[arc_pkg::L_B2] : cnt[arc_pkg::L_B1];
  assign ratio_one = (mine > other) || (mine == '0);
  assign div_start = (state == S_DEC) && do_acc && rd_vld && !ratio_one &&
                     (rd_lst == arc_pkg::L_B1 || rd_lst == arc_pkg::L_B2);

  assign res_x = XW'(cnt[arc_pkg::L_T1]) + XW'(cnt[arc_pkg::L_T2]);
  assign all_x = res_x + XW'(cnt[arc_pkg::L_B1]) + XW'(cnt[arc_pkg::L_B2]);
  assign cap_x = XW'(capacity);
  assign tgt_x = XW'(target);
  assign rr    = ratio_one_q ? CW'(1) : div_quo;
  assign np_x  = tgt_x + XW'(rr);

  // Pick the list to drop from and whether its loop goes on.
  always_comb begin
    drop_src  = arc_pkg::L_T1;
    drop_cond = 1'b0;
    unique case (state)
      S_REP1: begin
        drop_src  = arc_pkg::L_T1;
        drop_cond = (res_x > cap_x) && (XW'(cnt[arc_pkg::L_T1]) > tgt_x);
      end
      S_REP2: begin
        drop_src  = arc_pkg::L_T2;
        drop_cond = (res_x > cap_x) && (tgt_x <= cap_x) &&
                    (XW'(cnt[arc_pkg::L_T2]) > (cap_x - tgt_x));
      end
      S_TRIM1: begin
        drop_src  = (cnt[arc_pkg::L_B1] != '0) ? arc_pkg::L_B1 : arc_pkg::L_T1;
        drop_cond = (XW'(cnt[arc_pkg::L_T1]) + XW'(cnt[arc_pkg::L_B1])) > cap_x;
      end
      S_TRIM2: begin
        drop_src  = (cnt[arc_pkg::L_B2] != '0) ? arc_pkg::L_B2 : arc_pkg::L_T2;
        drop_cond = all_x > (cap_x << 1);
      end
      default: begin
        drop_src  = arc_pkg::L_T1;
        drop_cond = 1'b0;
      end
    endcase
  end

  // Node RAM port steering: each state either reads or writes, never both
  // on the same entry, so no forwarding is needed.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur[AW-1:0];
    ram_wdata = '0;
    ram_raddr = cur[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      S_IDLE:    ram_raddr = AW'(request.key);
      S_REP1, S_REP2, S_TRIM1, S_TRIM2: ram_raddr = tail[drop_src][AW-1:0];
      S_RM_P_RD: ram_raddr = cur_prev[AW-1:0];
      S_RM_N_RD: ram_raddr = cur_next[AW-1:0];
      S_IN_H_RD: ram_raddr = head[dst][AW-1:0];
      S_RM_P_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_prev[AW-1:0];
        ram_wdata = {rd_vld, rd_lst, rd_prev, cur_next};
      end
      S_RM_N_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_next[AW-1:0];
        ram_wdata = {rd_vld, rd_lst, cur_prev, rd_next};
      end
      S_RM_K_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cur[AW-1:0];
      end
      S_IN_K_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cur[AW-1:0];
        ram_wdata = {1'b1, dst, NULLP, head[dst]};
      end
      S_IN_H_WR: begin
        ram_we    = 1'b1;
        ram_waddr = head[dst][AW-1:0];
        ram_wdata = {rd_vld, rd_lst, cur, rd_next};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  arc_ram #(
    .WIDTH (NW),
    .DEPTH (NUM_KEYS)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  arc_div #(
    .W (CW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (other),
    .den   (mine),
    .quo   (div_quo),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      done        <= 1'b0;
      capacity    <= arc_pkg::CAP_RESET;
      set_on_miss <= 1'b1;
      target      <= '0;
      hit_cnt     <= '0;
      miss_cnt    <= '0;
      for (int i = 0; i < 4; i++) begin
        head[i] <= NULLP;
        tail[i] <= NULLP;
        cnt[i]  <= '0;
      end
    end else begin
      done <= 1'b0;

      // Register writes must arrive only while the walk is idle; the block does not enforce this.
      if (cfg_wr) begin
        if (paddr[2] == arc_pkg::REG_CAPACITY) begin
          capacity <= pwdata[FW-1:0];
          if (target > pwdata[FW-1:0]) begin
            target <= pwdata[FW-1:0];
          end
        end else begin
          set_on_miss <= pwdata[0];
        end
      end

      unique case (state)
        // Sweep every node to "no list" after reset.
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NUM_KEYS - 1)) begin
            state <= S_IDLE;
          end
        end

        // Take a request; the key's node read is issued this cycle.
        S_IDLE: begin
          if (start) begin
            op_q       <= request.operation;
            in_range_q <= in_range;
            cur        <= PW'(request.key);
            new_key    <= 1'b0;
            state      <= S_DEC;
          end
        end

        S_DEC: begin
          hit_q       <= in_range_q && rd_hit;
          cur_prev    <= rd_prev;
          cur_next    <= rd_next;
          cur_list    <= rd_lst;
          ratio_one_q <= ratio_one;
          if (in_range_q && op_q == arc_pkg::OP_GET) begin
            if (rd_hit) begin
              hit_cnt <= hit_cnt + 32'd1;
            end else begin
              miss_cnt <= miss_cnt + 32'd1;
            end
          end
          if (do_acc) begin
            ins_en <= 1'b1;
            dst    <= arc_pkg::L_T2;
            if (!rd_vld) begin
              // Brand new key: into T1, then replace and trim.
              new_key <= 1'b1;
              dst     <= arc_pkg::L_T1;
              ret     <= S_REP1;
              state   <= S_IN_K_WR;
            end else if (rd_hit) begin
              ret   <= S_FIN;
              state <= S_RM_P_RD;
            end else begin
              // Ghost hit: adapt the target first.
              ret   <= S_REP1;
              state <= ratio_one ? S_ADAPT : S_DIVW;
            end
          end else if (do_del) begin
            ins_en <= 1'b0;
            ret    <= S_FIN;
            state  <= S_RM_P_RD;
          end else begin
            state <= S_FIN;
          end
        end

        S_DIVW: begin
          if (div_done) begin
            state <= S_ADAPT;
          end
        end

        S_ADAPT: begin
          if (cur_list == arc_pkg::L_B1) begin
            target <= (np_x < cap_x) ? np_x[FW-1:0] : capacity;
          end else begin
            target <= (tgt_x < XW'(rr)) ? '0 : FW'(tgt_x - XW'(rr));
          end
          state <= S_RM_P_RD;
        end

        // Unlink cur from cur_list.
        S_RM_P_RD: begin
          cnt[cur_list] <= cnt[cur_list] - CW'(1);
          if (cur_prev == NULLP) begin
            head[cur_list] <= cur_next;
            state          <= S_RM_N_RD;
          end else begin
            state <= S_RM_P_WR;
          end
        end

        S_RM_P_WR: state <= S_RM_N_RD;

        S_RM_N_RD: begin
          if (cur_next == NULLP) begin
            tail[cur_list] <= cur_prev;
            state          <= ins_en ? S_IN_K_WR : S_RM_K_WR;
          end else begin
            state <= S_RM_N_WR;
          end
        end

        S_RM_N_WR: state <= ins_en ? S_IN_K_WR : S_RM_K_WR;

        S_RM_K_WR: state <= ret;

        // Link cur at the MRU end of dst.
        S_IN_K_WR: begin
          cnt[dst] <= cnt[dst] + CW'(1);
          if (head[dst] == NULLP) begin
            head[dst] <= cur;
            tail[dst] <= cur;
            state     <= ret;
          end else begin
            state <= S_IN_H_RD;
          end
        end

        S_IN_H_RD: state <= S_IN_H_WR;

        S_IN_H_WR: begin
          head[dst] <= cur;
          state     <= ret;
        end

        // Eviction and trim loops: each pass drops one LRU entry.
        S_REP1, S_REP2, S_TRIM1, S_TRIM2: begin
          if (drop_cond && cnt[drop_src] != '0) begin
            cur      <= tail[drop_src];
            cur_list <= drop_src;
            ret      <= state;
            ins_en   <= (state == S_REP1) || (state == S_REP2);
            dst      <= (state == S_REP1) ? arc_pkg::L_B1 : arc_pkg::L_B2;
            state    <= S_LRU;
          end else begin
            priority case (state)
              S_REP1:  state <= S_REP2;
              S_REP2:  state <= new_key ? S_TRIM1 : S_FIN;
              S_TRIM1: state <= S_TRIM2;
              default: state <= S_FIN;
            endcase
          end
        end

        S_LRU: begin
          cur_prev <= rd_prev;
          cur_next <= rd_next;
          state    <= S_RM_P_RD;
        end

        // Present the result for one cycle.
        S_FIN: begin
          done                  <= 1'b1;
          result.hit            <= hit_q;
          result.resident_count <= res_x[FW-1:0];
          result.target_recent  <= target;
          result.hit_total      <= hit_cnt;
          result.miss_total     <= miss_cnt;
          state                 <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `ASSERT_IMPLIES(a_clear_quiet, state == S_CLEAR, !done, "result during clearing sweep")
  `ASSERT_IMPLIES(a_res_bound, 1'b1, res_x <= XW'(NUM_KEYS), "resident count over key space")
endmodule
